// ===== src/ntc_thermistor_temperature_unit_assert.svh =====
`ifndef NTC_THERMISTOR_TEMPERATURE_UNIT_ASSERT_SVH
`define NTC_THERMISTOR_TEMPERATURE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NTCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define NTCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ntct_pkg.sv =====
`default_nettype none

package ntct_pkg;

	localparam int TABLE_ENTRIES  = 101;
	localparam int ADC_FULL_SCALE = 4096;
	localparam int CODE_W         = 12;
	localparam int SER_W          = 16;
	localparam int RES_W          = 28;
	localparam int DEN_W          = 13;
	localparam int TAB_W          = 18;
	localparam int IDX_W          = 7;
	localparam int ALU_W          = 29;
	localparam int CNT_W          = 5;
	localparam int TEMP_W         = 8;
	localparam int STAT_W         = 2;

	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [TEMP_W-1:0] COLDEST_C  = 8'd30;
	localparam logic [SER_W-1:0]  SER_RESET  = 16'd10000;
	localparam logic [CNT_W-1:0]  MUL_STEPS  = CNT_W'(CODE_W - 1);
	localparam logic [CNT_W-1:0]  DIV_STEPS  = CNT_W'(RES_W - 1);

	localparam logic [STAT_W-1:0] ST_IN_RANGE = 2'd0;
	localparam logic [STAT_W-1:0] ST_COLD     = 2'd1;
	localparam logic [STAT_W-1:0] ST_HOT      = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_SRCH,
		S_FIN
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_ctl_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             ge;
	} alu_res_t;

	// Thermistor resistance in ohms, one entry per degree from -30 C up.
	function automatic logic [TAB_W-1:0] res_table(input logic [IDX_W-1:0] idx);
		logic [TAB_W-1:0] v;
		case (idx)
			7'd0:   v = 18'd177370;  7'd1:   v = 18'd166660;  7'd2:   v = 18'd156670;
			7'd3:   v = 18'd147340;  7'd4:   v = 18'd138630;  7'd5:   v = 18'd130490;
			7'd6:   v = 18'd122880;  7'd7:   v = 18'd115760;  7'd8:   v = 18'd109100;
			7'd9:   v = 18'd102860;  7'd10:  v = 18'd97026;   7'd11:  v = 18'd91554;
			7'd12:  v = 18'd86425;   7'd13:  v = 18'd81616;   7'd14:  v = 18'd77104;
			7'd15:  v = 18'd72869;   7'd16:  v = 18'd68893;   7'd17:  v = 18'd65159;
			7'd18:  v = 18'd61650;   7'd19:  v = 18'd58351;   7'd20:  v = 18'd55249;
			7'd21:  v = 18'd52330;   7'd22:  v = 18'd49584;   7'd23:  v = 18'd46998;
			7'd24:  v = 18'd44562;   7'd25:  v = 18'd42268;   7'd26:  v = 18'd40105;
			7'd27:  v = 18'd38065;   7'd28:  v = 18'd36142;   7'd29:  v = 18'd34327;
			7'd30:  v = 18'd32614;   7'd31:  v = 18'd30996;   7'd32:  v = 18'd29468;
			7'd33:  v = 18'd28025;   7'd34:  v = 18'd26660;   7'd35:  v = 18'd25370;
			7'd36:  v = 18'd24150;   7'd37:  v = 18'd22995;   7'd38:  v = 18'd21902;
			7'd39:  v = 18'd20868;   7'd40:  v = 18'd19888;   7'd41:  v = 18'd18960;
			7'd42:  v = 18'd18080;   7'd43:  v = 18'd17246;   7'd44:  v = 18'd16456;
			7'd45:  v = 18'd15706;   7'd46:  v = 18'd14994;   7'd47:  v = 18'd14319;
			7'd48:  v = 18'd13677;   7'd49:  v = 18'd13069;   7'd50:  v = 18'd12490;
			7'd51:  v = 18'd11940;   7'd52:  v = 18'd11418;   7'd53:  v = 18'd10921;
			7'd54:  v = 18'd10449;   7'd55:  v = 18'd10000;   7'd56:  v = 18'd9572;
			7'd57:  v = 18'd9165;    7'd58:  v = 18'd8777;    7'd59:  v = 18'd8408;
			7'd60:  v = 18'd8057;    7'd61:  v = 18'd7722;    7'd62:  v = 18'd7403;
			7'd63:  v = 18'd7099;    7'd64:  v = 18'd6808;    7'd65:  v = 18'd6532;
			7'd66:  v = 18'd6268;    7'd67:  v = 18'd6016;    7'd68:  v = 18'd5775;
			7'd69:  v = 18'd5545;    7'd70:  v = 18'd5326;    7'd71:  v = 18'd5117;
			7'd72:  v = 18'd4916;    7'd73:  v = 18'd4725;    7'd74:  v = 18'd4542;
			7'd75:  v = 18'd4368;    7'd76:  v = 18'd4200;    7'd77:  v = 18'd4040;
			7'd78:  v = 18'd3887;    7'd79:  v = 18'd3741;    7'd80:  v = 18'd3601;
			7'd81:  v = 18'd3467;    7'd82:  v = 18'd3338;    7'd83:  v = 18'd3215;
			7'd84:  v = 18'd3097;    7'd85:  v = 18'd2984;    7'd86:  v = 18'd2876;
			7'd87:  v = 18'd2772;    7'd88:  v = 18'd2672;    7'd89:  v = 18'd2577;
			7'd90:  v = 18'd2485;    7'd91:  v = 18'd2397;    7'd92:  v = 18'd2313;
			7'd93:  v = 18'd2232;    7'd94:  v = 18'd2154;    7'd95:  v = 18'd2080;
			7'd96:  v = 18'd2008;    7'd97:  v = 18'd1939;    7'd98:  v = 18'd1873;
			7'd99:  v = 18'd1809;    7'd100: v = 18'd1748;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== src/ntct_addsub.sv =====
`default_nettype none

module ntct_addsub (
	input  ntct_pkg::alu_ctl_t ctl,
	output ntct_pkg::alu_res_t res
);

	logic [ntct_pkg::ALU_W:0]   full;
	logic [ntct_pkg::ALU_W-1:0] b_eff;
	logic                       cin;

	always_comb begin
		cin   = (ctl.op == ntct_pkg::ALU_SUB);
		b_eff = cin ? ~ctl.b : ctl.b;
		full  = {1'b0, ctl.a} + {1'b0, b_eff} + {{ntct_pkg::ALU_W{1'b0}}, cin};
		res.sum = full[ntct_pkg::ALU_W-1:0];
		// For a subtract, carry out set means a >= b.
		res.ge  = full[ntct_pkg::ALU_W];
	end

endmodule

`default_nettype wire

// ===== src/ntc_thermistor_temperature_unit.sv =====
// Channel   Dir  Payload (lowest bit first)
// s_axis    in   s_tdata[11:0] ntc_code, [15:12] zero
// m_axis    out  m_tdata[7:0] temperature_c, [35:8] resistance_ohms,
//                [37:36] range_status, [39:38] zero
// cfg       in   cfg_data[15:0] series_resistance_ohms
//
// Each item is accepted, then runs 12 shift-add multiply steps, 28 restoring
// divide steps, six or seven binary table search steps, a step in which the
// search bounds meet and one final compare, all through the single shared
// 29-bit adder/subtractor.
// Reset clears the control state and loads the series resistor with 10000.
// A waiting result does not block acceptance of the next item; the final step
// holds only while a previous result is still not taken.
`default_nettype none

module ntc_thermistor_temperature_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [15:0] s_tdata,   // ntc_code[11:0], zero fill
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [39:0] m_tdata,   // temperature_c, resistance_ohms, range_status
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [15:0] cfg_data
);

	`include "ntc_thermistor_temperature_unit_assert.svh"

	ntct_pkg::state_t state_q, state_d;

	logic [ntct_pkg::SER_W-1:0]  ser_q;
	logic [ntct_pkg::CODE_W-1:0] code_q;
	logic [ntct_pkg::RES_W-1:0]  acc_q;
	logic [ntct_pkg::DEN_W-1:0]  rem_q;
	logic [ntct_pkg::DEN_W-1:0]  den_q;
	logic [ntct_pkg::CNT_W-1:0]  cnt_q;
	logic [ntct_pkg::IDX_W-1:0]  lo_q, hi_q;

	logic                         out_valid_q;
	logic [ntct_pkg::TEMP_W-1:0]  out_temp_q;
	logic [ntct_pkg::RES_W-1:0]   out_res_q;
	logic [ntct_pkg::STAT_W-1:0]  out_stat_q;

	ntct_pkg::alu_ctl_t alu_ctl;
	ntct_pkg::alu_res_t alu_res;

	logic [ntct_pkg::IDX_W:0]     mid_sum;
	logic [ntct_pkg::IDX_W-1:0]   mid;
	logic [ntct_pkg::IDX_W-1:0]   tab_idx;
	logic [ntct_pkg::TAB_W-1:0]   tab_val;
	logic                         in_acc;
	logic                         out_free;
	logic                         fin_load;
	logic [ntct_pkg::STAT_W-1:0]  fin_stat;

	assign s_tready  = (state_q == ntct_pkg::S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign fin_load  = (state_q == ntct_pkg::S_FIN) && out_free;
	assign cfg_ready = 1'b1;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[ntct_pkg::IDX_W:1];
	assign tab_idx = (state_q == ntct_pkg::S_FIN) ? lo_q : mid;
	assign tab_val = ntct_pkg::res_table(tab_idx);

	always_comb begin
		alu_ctl.op = ntct_pkg::ALU_SUB;
		alu_ctl.a  = '0;
		alu_ctl.b  = '0;
		case (state_q)
			ntct_pkg::S_MUL: begin
				alu_ctl.op = ntct_pkg::ALU_ADD;
				alu_ctl.a  = {1'b0, acc_q[ntct_pkg::RES_W-2:0], 1'b0};
				alu_ctl.b  = {13'd0, code_q[ntct_pkg::CODE_W-1] ? ser_q : 16'd0};
			end
			ntct_pkg::S_DIV: begin
				alu_ctl.a = {15'd0, rem_q, acc_q[ntct_pkg::RES_W-1]};
				alu_ctl.b = {16'd0, den_q};
			end
			ntct_pkg::S_SRCH, ntct_pkg::S_FIN: begin
				alu_ctl.a = {1'b0, acc_q};
				alu_ctl.b = {11'd0, tab_val};
			end
			default: begin
				alu_ctl.a = '0;
			end
		endcase
	end

	ntct_addsub u_addsub (
		.ctl (alu_ctl),
		.res (alu_res)
	);

	// The search never lands on the last entry as a midpoint, so the final
	// compare decides whether the resistance fell below the whole table.
	always_comb begin
		if (lo_q == '0) begin
			fin_stat = ntct_pkg::ST_COLD;
		end else if (lo_q == ntct_pkg::LAST_IDX && !alu_res.ge) begin
			fin_stat = ntct_pkg::ST_HOT;
		end else begin
			fin_stat = ntct_pkg::ST_IN_RANGE;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ntct_pkg::S_IDLE: begin
				if (in_acc) state_d = ntct_pkg::S_MUL;
			end
			ntct_pkg::S_MUL: begin
				if (cnt_q == '0) state_d = ntct_pkg::S_DIV;
			end
			ntct_pkg::S_DIV: begin
				if (cnt_q == '0) state_d = ntct_pkg::S_SRCH;
			end
			ntct_pkg::S_SRCH: begin
				if (lo_q == hi_q) state_d = ntct_pkg::S_FIN;
			end
			ntct_pkg::S_FIN: begin
				if (out_free) state_d = ntct_pkg::S_IDLE;
			end
			default: begin
				state_d = ntct_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ntct_pkg::S_IDLE;
			ser_q       <= ntct_pkg::SER_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) ser_q <= cfg_data;
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ntct_pkg::S_IDLE: begin
				code_q <= s_tdata[ntct_pkg::CODE_W-1:0];
				den_q  <= ntct_pkg::DEN_W'(ntct_pkg::ADC_FULL_SCALE)
					- {1'b0, s_tdata[ntct_pkg::CODE_W-1:0]};
				acc_q  <= '0;
				cnt_q  <= ntct_pkg::MUL_STEPS;
			end
			ntct_pkg::S_MUL: begin
				acc_q  <= alu_res.sum[ntct_pkg::RES_W-1:0];
				code_q <= {code_q[ntct_pkg::CODE_W-2:0], 1'b0};
				rem_q  <= '0;
				cnt_q  <= (cnt_q == '0) ? ntct_pkg::DIV_STEPS : cnt_q - 1'b1;
			end
			ntct_pkg::S_DIV: begin
				if (alu_res.ge) rem_q <= alu_res.sum[ntct_pkg::DEN_W-1:0];
				else rem_q <= {rem_q[ntct_pkg::DEN_W-2:0], acc_q[ntct_pkg::RES_W-1]};
				acc_q <= {acc_q[ntct_pkg::RES_W-2:0], alu_res.ge};
				cnt_q <= cnt_q - 1'b1;
				lo_q  <= '0;
				hi_q  <= ntct_pkg::LAST_IDX;
			end
			ntct_pkg::S_SRCH: begin
				if (lo_q != hi_q) begin
					if (alu_res.ge) hi_q <= mid;
					else lo_q <= mid + 1'b1;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
		if (fin_load) begin
			out_temp_q <= {1'b0, lo_q} - ntct_pkg::COLDEST_C;
			out_res_q  <= acc_q;
			out_stat_q <= fin_stat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_stat_q, out_res_q, out_temp_q};

	`NTCT_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_acc, state_q == ntct_pkg::S_MUL, "accepted item did not start the multiply")
	`NTCT_ASSERT_NOW(a_div_rem, clk, arst_n, state_q == ntct_pkg::S_DIV, rem_q < den_q, "division remainder not below divisor")
	`NTCT_ASSERT_NOW(a_search_order, clk, arst_n, state_q == ntct_pkg::S_SRCH, lo_q <= hi_q && hi_q <= ntct_pkg::LAST_IDX, "search bounds crossed")
	`NTCT_ASSERT_NOW(a_clamp_temp, clk, arst_n, m_tvalid && out_stat_q != ntct_pkg::ST_IN_RANGE, out_temp_q == 8'sd70 || out_temp_q == 8'hE2, "clamped result has an inner temperature")

endmodule

`default_nettype wire
